[rtl/core/itaf_pkg.sv]
// Shared types, character codes and helpers for the integer-to-ASCII formatter.
package itaf_pkg;

    // Default width of the value being formatted
    localparam int VALUE_BITS_DEF = 32;

    // Bit positions inside the operation code
    localparam int OP_SIGNED_BIT = 0;
    localparam int OP_HEX_BIT    = 1;

    // Character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_ALPHA = 8'h37;  // 'A' - 10
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_LOAD,
        ST_SIGN,
        ST_SCAN
    } itaf_state_t;

    // Load / shift strobes for a shift-register unit
    typedef struct packed {
        logic load;
        logic shift;
    } itaf_ctl_t;

    // Emitter status toward the sequencer
    typedef struct packed {
        logic       fire;       // current digit is printed
        logic       final_pos;  // current digit is the last position
        logic [3:0] digit;      // current (most significant) digit
    } itaf_emit_stat_t;

    // One digit (0-15) to its ASCII code
    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
        logic [7:0] code;
        if (d < 4'd10) begin
            code = CHAR_ZERO + {4'b0000, d};
        end else begin
            code = CHAR_ALPHA + {4'b0000, d};
        end
        return code;
    endfunction

endpackage

[rtl/core/itaf_dabble.sv]
// Bit-serial double-dabble converter: one magnitude bit shifted into the BCD word per cycle while shift is set.
module itaf_dabble
    import itaf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int NDIG       = 10
) (
    input  logic                   clk,
    input  itaf_ctl_t              ctl,
    input  logic [VALUE_BITS-1:0]  mag,
    output logic [VALUE_BITS-1:0]  mag_out,
    output logic [4*NDIG-1:0]      bcd_out
);

    localparam int DIG_W = 4 * NDIG;

    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic [DIG_W-1:0]      bcd_reg;
    logic [DIG_W-1:0]      bcd_next;
    logic [DIG_W-1:0]      bcd_adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Load or shift
    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        if (ctl.load) begin
            mag_next = mag;
            bcd_next = '0;
        end else if (ctl.shift) begin
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = {bcd_adj[DIG_W-2:0], mag_reg[VALUE_BITS-1]};
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign mag_out = mag_reg;
    assign bcd_out = bcd_reg;

endmodule

[rtl/core/itaf_emit.sv]
// Digit emitter: shifts digits out most significant first and suppresses leading zeros.
module itaf_emit
    import itaf_pkg::*;
#(
    parameter int NDIG = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  itaf_ctl_t         ctl,
    input  logic [4*NDIG-1:0] digits,
    output itaf_emit_stat_t   stat
);

    localparam int DIG_W = 4 * NDIG;
    localparam int CNT_W = $clog2(NDIG + 1);

    logic [DIG_W-1:0] dig_reg;
    logic [DIG_W-1:0] dig_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             started_reg;
    logic             started_next;

    // Status of the digit at the top of the register
    always_comb
    begin
        stat.digit     = dig_reg[DIG_W-1 -: 4];
        stat.final_pos = (cnt_reg == CNT_W'(1));
        stat.fire      = started_reg || (stat.digit != 4'd0) || stat.final_pos;
    end

    // Load or shift by one digit
    always_comb
    begin
        dig_next     = dig_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        if (ctl.load) begin
            dig_next     = digits;
            cnt_next     = CNT_W'(NDIG);
            started_next = 1'b0;
        end else if (ctl.shift) begin
            dig_next     = {dig_reg[DIG_W-5:0], 4'b0000};
            cnt_next     = cnt_reg - CNT_W'(1);
            started_next = started_reg || stat.fire;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg     <= '0;
            started_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
        end
    end

    // Digit payload
    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
    end

endmodule

[rtl/core/int_to_ascii_formatter.sv]
// Top level of the integer-to-ASCII formatter: sequencer, sign handling and output register.
//
// A transaction is taken when start is high and busy is low; the value is then
// printed as a string, one character per strobe cycle, most significant first,
// with last set on the final character. The receiver cannot stall: every strobe
// cycle carries a character that must be taken. Decimal modes first run the
// double-dabble shift steps (one bit per cycle, VALUE_BITS bits), then a load
// step, a step for a '-' if the value is negative, then a scan over all NDIG
// digit positions (10 at 32 bits), leading zeros being skipped silently.
// Hex mode skips the shift steps. busy stays high for the whole transaction
// and the next one may start on the edge where the final character goes out.
module int_to_ascii_formatter
    import itaf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            operation,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  strobe,
    output logic [7:0]            char_code,
    output logic                  last
);

    localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_W      = 4 * NDIG;
    localparam int STEP_W     = $clog2(VALUE_BITS);

    itaf_state_t           state_reg;
    itaf_state_t           state_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic                  hex_reg;
    logic                  hex_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  strobe_reg;
    logic                  strobe_next;
    logic [7:0]            char_reg;
    logic [7:0]            char_next;
    logic                  last_reg;
    logic                  last_next;

    logic                  accept;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic [VALUE_BITS-1:0] dab_mag;
    logic [DIG_W-1:0]      dab_bcd;
    logic [DIG_W-1:0]      emit_src;
    itaf_ctl_t             dab_ctl;
    itaf_ctl_t             emit_ctl;
    itaf_emit_stat_t       emit_stat;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Sign and magnitude of the incoming value
    assign in_neg = !operation[OP_HEX_BIT] && operation[OP_SIGNED_BIT]
                    && value[VALUE_BITS-1];
    assign in_mag = in_neg ? (~value + VALUE_BITS'(1)) : value;

    // Emitter source: raw nibbles in hex, BCD digits in decimal
    assign emit_src = hex_reg ? DIG_W'(dab_mag) : dab_bcd;

    itaf_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_dabble (
        .clk     (clk),
        .ctl     (dab_ctl),
        .mag     (in_mag),
        .mag_out (dab_mag),
        .bcd_out (dab_bcd)
    );

    itaf_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (emit_ctl),
        .digits (emit_src),
        .stat   (emit_stat)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    state_next = operation[OP_HEX_BIT] ? ST_LOAD : ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (step_reg == '0) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = neg_reg ? ST_SIGN : ST_SCAN;
            end
            ST_SIGN:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (emit_stat.final_pos) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        dab_ctl     = '0;
        emit_ctl    = '0;
        step_next   = step_reg;
        hex_next    = hex_reg;
        neg_next    = neg_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    dab_ctl.load = 1'b1;
                    step_next    = STEP_W'(VALUE_BITS - 1);
                    hex_next     = operation[OP_HEX_BIT];
                    neg_next     = in_neg;
                end
            end
            ST_CONVERT:
            begin
                dab_ctl.shift = 1'b1;
                step_next     = step_reg - STEP_W'(1);
            end
            ST_LOAD:
            begin
                emit_ctl.load = 1'b1;
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_MINUS;
                last_next   = 1'b0;
            end
            ST_SCAN:
            begin
                emit_ctl.shift = 1'b1;
                strobe_next    = emit_stat.fire;
                char_next      = digit_to_ascii(emit_stat.digit);
                last_next      = emit_stat.final_pos;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            hex_reg    <= 1'b0;
            neg_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            hex_reg    <= hex_next;
            neg_reg    <= neg_next;
            strobe_reg <= strobe_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

    // A character only goes out while a transaction is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("character strobe outside a transaction");

    // An accepted transaction makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    // Nothing follows the final character directly
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("character emitted right after the final one");

    // The sign cycle puts out a minus that is never the final character
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |=> (strobe && (char_code == CHAR_MINUS) && !last))
        else $error("minus sign not emitted correctly");

endmodule
